// ===== hw/rtl/bilinear_upscale_2x_int8_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the 2x bilinear upscaler
// Shared forms for the concurrent checks, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef BILINEAR_UPSCALE_2X_INT8_ASSERT_SVH
`define BILINEAR_UPSCALE_2X_INT8_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BU2X_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bu2x check failed");

// The consequent must hold in the cycle after the antecedent.
`define BU2X_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bu2x check failed");

`endif

// ===== hw/rtl/bu2x_pkg.sv =====
// ---------------------------------------------------------------------------
// bu2x_pkg
// Types, sizes and helper functions shared by the 2x bilinear upscaler.
// ---------------------------------------------------------------------------
package bu2x_pkg;

  // Largest source plane supported; the row store holds one row of this width.
  localparam int unsigned MAX_WIDTH  = 128;
  localparam int unsigned MAX_HEIGHT = 128;

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = $clog2(MAX_HEIGHT);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SRC_HEIGHT  = 2'd0,
    CFG_SRC_WIDTH   = 2'd1,
    CFG_PLANE_COUNT = 2'd2
  } cfg_idx_t;

  // Kind of destination row or column relative to its source sample:
  // the interpolated one before it, the direct copy, or the edge copy after it.
  typedef enum logic [1:0] {
    K_INTERP = 2'd0,
    K_COPY   = 2'd1,
    K_EDGE   = 2'd2
  } kind_t;

  // One accepted source pixel with its neighbors and position flags.
  typedef struct packed {
    logic signed [7:0] cur;
    logic signed [7:0] left;
    logic signed [7:0] ul;
    logic [RowW-1:0]   row;
    logic [ColW-1:0]   col;
    logic [15:0]       plane;
    logic              has_up;
    logic              has_left;
    logic              last_row;
    logic              last_col;
    logic              frame_end;
  } item_t;

  // Floor of the mean of two signed samples.
  function automatic logic signed [7:0] floor_mean(logic signed [7:0] a,
                                                   logic signed [7:0] b);
    logic [8:0] s;
    s = {a[7], a} + {b[7], b};
    return s[8:1];
  endfunction

endpackage

// ===== hw/rtl/bu2x_emit.sv =====
// ---------------------------------------------------------------------------
// bu2x_emit
// Holds one source item and walks its 1 to 9 destination pixels into the
// result register, one per cycle while out_tready does not stall the result register.
// ---------------------------------------------------------------------------
`include "bilinear_upscale_2x_int8_assert.svh"

module bu2x_emit
  import bu2x_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Item load from the source side
  input  logic              load,
  input  item_t             item,
  input  logic signed [7:0] up_pix,     // upper sample, valid from the load edge on
  output logic              can_load,
  // Result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata,  // pixel_out[7:0], out_row[15:8], out_col[23:16],
                                        // out_plane[39:24]
  output logic              out_tuser,  // last_of_item
  output logic              out_tlast   // last_of_frame
);

  localparam int unsigned RowCW = RowW + 2;
  localparam int unsigned ColCW = ColW + 2;

  item_t it_r;
  logic  item_v_r;
  kind_t row_k_r, row_k_nxt;
  kind_t col_k_r, col_k_nxt;

  logic        out_v_r;
  logic [39:0] out_data_r;
  logic        out_user_r;
  logic        out_last_r;

  logic  fire;
  logic  last_res;
  kind_t row_end, col_end, col_start;

  logic signed [7:0] h_cur, h_up, pix;
  logic [RowCW-1:0]  drow;
  logic [ColCW-1:0]  dcol;

  // Span of row and column kinds this item produces.
  always_comb begin
    col_start = it_r.has_left ? K_INTERP : K_COPY;
    row_end   = it_r.last_row ? K_EDGE : K_COPY;
    col_end   = it_r.last_col ? K_EDGE : K_COPY;
  end

  assign fire     = item_v_r && (!out_v_r || out_tready);
  assign last_res = (row_k_r == row_end) && (col_k_r == col_end);
  assign can_load = !item_v_r || (fire && last_res);

  // Next position in row-then-column order.
  always_comb begin
    row_k_nxt = row_k_r;
    col_k_nxt = col_k_r;
    if (col_k_r == col_end) begin
      col_k_nxt = col_start;
      unique case (row_k_r)
        K_INTERP: row_k_nxt = K_COPY;
        K_COPY:   row_k_nxt = K_EDGE;
        default:  row_k_nxt = K_EDGE;
      endcase
    end else begin
      unique case (col_k_r)
        K_INTERP: col_k_nxt = K_COPY;
        K_COPY:   col_k_nxt = K_EDGE;
        default:  col_k_nxt = K_EDGE;
      endcase
    end
  end

  // Horizontal mean first, then vertical mean of the two horizontal results.
  always_comb begin
    if (col_k_r == K_INTERP) begin
      h_cur = floor_mean(it_r.left, it_r.cur);
      h_up  = floor_mean(it_r.ul, up_pix);
    end else begin
      h_cur = it_r.cur;
      h_up  = up_pix;
    end
    pix = (row_k_r == K_INTERP) ? floor_mean(h_up, h_cur) : h_cur;
  end

  // Destination coordinate is twice the source position, offset by kind - 1.
  assign drow = {1'b0, it_r.row, 1'b0} + RowCW'(row_k_r) - RowCW'(1);
  assign dcol = {1'b0, it_r.col, 1'b0} + ColCW'(col_k_r) - ColCW'(1);

  // Item register and kind sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      row_k_r  <= K_COPY;
      col_k_r  <= K_COPY;
    end else if (load) begin
      item_v_r <= 1'b1;
      row_k_r  <= item.has_up   ? K_INTERP : K_COPY;
      col_k_r  <= item.has_left ? K_INTERP : K_COPY;
    end else if (fire) begin
      if (last_res) begin
        item_v_r <= 1'b0;
      end else begin
        row_k_r <= row_k_nxt;
        col_k_r <= col_k_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      it_r <= item;
    end
  end

  // Result register: refilled on every transfer while an item is pending.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {it_r.plane, 8'(dcol), 8'(drow), pix};
      out_user_r <= last_res;
      out_last_r <= last_res && it_r.frame_end;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  `BU2X_ASSERT_SAME(a_load_only_when_free, load, can_load)
  `BU2X_ASSERT_SAME(a_kind_in_range, item_v_r, (row_k_r != 2'd3) && (col_k_r != 2'd3))
  `BU2X_ASSERT_NEXT(a_item_drains, fire && last_res && !load, !item_v_r)
  `BU2X_ASSERT_SAME(a_frame_end_ends_item, out_tvalid && out_tlast, out_tuser)

endmodule

// ===== hw/rtl/bilinear_upscale_2x_int8.sv =====
// ---------------------------------------------------------------------------
// bilinear_upscale_2x_int8
// Streaming 2x bilinear upscaler for signed 8-bit planes in raster order.
// ---------------------------------------------------------------------------
// Each source pixel produces 1 to 9 destination pixels (four on average), and
// the result port delivers one per cycle while out_tready does not hold it
// back. The next source pixel is taken in the same cycle that the last result
// of the current one enters the result register, so the input never waits on
// an idle bubble. Results carry their destination row, column and plane; tuser
// marks the last result of each source pixel and tlast the final pixel of the
// last plane. The previous row is kept in a one-row store; any configuration
// write restarts the frame at row, column and plane zero and must happen only
// while the block is idle.
// ---------------------------------------------------------------------------
module bilinear_upscale_2x_int8
  import bu2x_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  // Source pixels
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // pixel_in[7:0]
  // Destination pixels
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // pixel_out[7:0], out_row[15:8], out_col[23:16],
                                  // out_plane[39:24]
  output logic        out_tuser,  // last_of_item
  output logic        out_tlast   // last_of_frame
);

  logic [7:0]  src_height_r;
  logic [7:0]  src_width_r;
  logic [15:0] plane_count_r;

  logic [RowW-1:0] row_pos_r;
  logic [ColW-1:0] col_pos_r;
  logic [15:0]     plane_pos_r;

  logic signed [7:0] prev_pix_r;
  logic signed [7:0] up_r;
  logic [7:0]        row_mem [MAX_WIDTH];

  logic [ColW:0] w_eff;
  logic [RowW:0] h_eff;
  logic [15:0]   p_eff;

  logic [ColW-1:0] c_cl;
  logic [RowW-1:0] r_cl;
  logic [15:0]     p_cl;
  logic            last_col, last_row, last_plane;

  logic  can_load;
  logic  accept;
  logic  cfg_hit;
  item_t item;

  // Effective sizes: zero acts as one, oversize clamps to MAX_WIDTH and MAX_HEIGHT.
  always_comb begin
    if (src_width_r == 8'd0) begin
      w_eff = (ColW + 1)'(1);
    end else if (32'(src_width_r) > MAX_WIDTH) begin
      w_eff = (ColW + 1)'(MAX_WIDTH);
    end else begin
      w_eff = (ColW + 1)'(src_width_r);
    end
    if (src_height_r == 8'd0) begin
      h_eff = (RowW + 1)'(1);
    end else if (32'(src_height_r) > MAX_HEIGHT) begin
      h_eff = (RowW + 1)'(MAX_HEIGHT);
    end else begin
      h_eff = (RowW + 1)'(src_height_r);
    end
    p_eff = (plane_count_r == 16'd0) ? 16'd1 : plane_count_r;
  end

  // Current position, wrapped in case it lies outside the plane.
  always_comb begin
    c_cl = ({1'b0, col_pos_r} >= w_eff) ? '0 : col_pos_r;
    r_cl = ({1'b0, row_pos_r} >= h_eff) ? '0 : row_pos_r;
    p_cl = (plane_pos_r >= p_eff) ? 16'd0 : plane_pos_r;
    last_col   = ({1'b0, c_cl} == w_eff - (ColW + 1)'(1));
    last_row   = ({1'b0, r_cl} == h_eff - (RowW + 1)'(1));
    last_plane = (p_cl == p_eff - 16'd1);
  end

  assign in_tready = can_load;
  assign accept    = in_tvalid && can_load;

  // The left neighbor is the previous pixel; the upper-left one is the
  // upper sample read for the previous pixel.
  always_comb begin
    item.cur       = in_tdata;
    item.left      = prev_pix_r;
    item.ul        = up_r;
    item.row       = r_cl;
    item.col       = c_cl;
    item.plane     = p_cl;
    item.has_up    = (r_cl != '0);
    item.has_left  = (c_cl != '0);
    item.last_row  = last_row;
    item.last_col  = last_col;
    item.frame_end = last_row && last_col && last_plane;
  end

  // Configuration registers.
  always_comb begin
    unique case (cfg_idx_t'(cfg_addr))
      CFG_SRC_HEIGHT, CFG_SRC_WIDTH, CFG_PLANE_COUNT: cfg_hit = cfg_wr_en;
      default:                                        cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_height_r  <= 8'd1;
      src_width_r   <= 8'd1;
      plane_count_r <= 16'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_SRC_HEIGHT:  src_height_r  <= cfg_wdata[7:0];
        CFG_SRC_WIDTH:   src_width_r   <= cfg_wdata[7:0];
        CFG_PLANE_COUNT: plane_count_r <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  // Raster position; a configuration write restarts the frame.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      row_pos_r   <= '0;
      col_pos_r   <= '0;
      plane_pos_r <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_pos_r <= '0;
        if (last_row) begin
          row_pos_r   <= '0;
          plane_pos_r <= last_plane ? 16'd0 : p_cl + 16'd1;
        end else begin
          row_pos_r   <= r_cl + RowW'(1);
          plane_pos_r <= p_cl;
        end
      end else begin
        col_pos_r   <= c_cl + ColW'(1);
        row_pos_r   <= r_cl;
        plane_pos_r <= p_cl;
      end
    end
  end

  // Row store: read the upper sample and write the new pixel at one address.
  always_ff @(posedge clk) begin
    if (accept) begin
      row_mem[c_cl] <= in_tdata;
      up_r          <= row_mem[c_cl];
      prev_pix_r    <= in_tdata;
    end
  end

  bu2x_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .item       (item),
    .up_pix     (up_r),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
